### sv/oblr_pkg.sv
package oblr_pkg;
   localparam int SAMPLE_BITS = 16;
   localparam int CFG_W   = 40;
   localparam int FREQ_W  = 41;
   localparam int SUM_W   = 34;
   localparam int RATIO_W = 32;
   localparam int MAG_W   = SAMPLE_BITS + 1;
   localparam int QW      = 4;

   localparam logic [2:0] REG_START_FREQ = 3'd0;
   localparam logic [2:0] REG_FREQ_STEP  = 3'd1;
   localparam logic [2:0] REG_WIN_A_LOW  = 3'd2;
   localparam logic [2:0] REG_WIN_A_HIGH = 3'd3;
   localparam logic [2:0] REG_WIN_B_LOW  = 3'd4;
   localparam logic [2:0] REG_WIN_B_HIGH = 3'd5;

   typedef struct packed {
      logic [MAG_W-1:0] vis_mag;
      logic [MAG_W-1:0] bp_mag;
      logic             hit;
      logic             last;
   } chan_type;

   typedef enum logic [1:0] {
      ST_ACC,
      ST_DIV,
      ST_OUT
   } back_state_type;
endpackage

### sv/oblr_isqrt.sv
// pipelined floor square root, one result bit per stage
module oblr_isqrt
   import oblr_pkg::*;
#(
   parameter int IN_W  = 34,
   parameter int OUT_W = 17,
   parameter int TAG_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [IN_W-1:0]    in_x,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output logic [OUT_W-1:0]   out_root,
   output logic [TAG_W-1:0]   out_tag
);
   localparam int XW = 2 * OUT_W;

   logic [XW-1:0]    x_ff   [OUT_W];
   logic [OUT_W-1:0] r_ff   [OUT_W];
   logic [TAG_W-1:0] tag_ff [OUT_W];
   logic             v_ff   [OUT_W];

   genvar g;
   generate
      for (g = 0; g < OUT_W; g++) begin : g_stage
         localparam int B = OUT_W - 1 - g;
         logic [XW-1:0]    x_prev;
         logic [OUT_W-1:0] r_prev;
         logic [TAG_W-1:0] t_prev;
         logic             v_prev;
         logic [XW-1:0]    trial;
         logic [XW-1:0]    x_in;
         logic [OUT_W-1:0] r_in;
         if (g == 0) begin : g_head
            assign x_prev = XW'(in_x);
            assign r_prev = '0;
            assign t_prev = in_tag;
            assign v_prev = in_valid;
         end else begin : g_body
            assign x_prev = x_ff[g-1];
            assign r_prev = r_ff[g-1];
            assign t_prev = tag_ff[g-1];
            assign v_prev = v_ff[g-1];
         end
         always_comb begin
            // (r + 2^b)^2 - r^2, bits of r below b+1 are still clear
            trial = (XW'(r_prev) << (B + 1)) + (XW'(1) << (2 * B));
            if (x_prev >= trial) begin
               x_in = x_prev - trial;
               r_in = r_prev | (OUT_W'(1) << B);
            end else begin
               x_in = x_prev;
               r_in = r_prev;
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[g] <= 1'b0;
            end else if (en) begin
               v_ff[g] <= v_prev;
            end
            if (en) begin
               x_ff[g]   <= x_in;
               r_ff[g]   <= r_in;
               tag_ff[g] <= t_prev;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[OUT_W-1];
   assign out_root  = r_ff[OUT_W-1];
   assign out_tag   = tag_ff[OUT_W-1];
endmodule

### sv/oblr_front.sv
// frequency tracking, window test and magnitude pipelines
module oblr_front
   import oblr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] vis_re,
   input  logic [SAMPLE_BITS-1:0] vis_im,
   input  logic [SAMPLE_BITS-1:0] bp_re,
   input  logic [SAMPLE_BITS-1:0] bp_im,
   input  logic                   last,
   input  logic [CFG_W-1:0]       start_freq,
   input  logic [CFG_W-1:0]       freq_step,
   input  logic [CFG_W-1:0]       win_a_low,
   input  logic [CFG_W-1:0]       win_a_high,
   input  logic [CFG_W-1:0]       win_b_low,
   input  logic [CFG_W-1:0]       win_b_high,
   input  logic                   q_ready,
   output logic                   q_valid,
   output chan_type               q_data
);
   localparam int SQ_W  = 2 * SAMPLE_BITS + 1;
   localparam int RT_W  = (SQ_W + 1) / 2;

   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic              at_start_ff;
   logic [FREQ_W-1:0] f_cur;
   logic              hit;
   logic              accept;

   // square stage registers
   logic                 s_valid_ff;
   logic [SQ_W-1:0]      vsq_ff, bsq_ff;
   logic [1:0]           s_tag_ff;
   logic [SAMPLE_BITS-1:0] avr, avi, abr, abi;

   logic                 en;
   logic                 v_out, b_out;
   logic [RT_W-1:0]      v_root, b_root;
   logic [1:0]           v_tag;
   logic                 b_tag;

   assign en        = !q_valid || q_ready;
   assign req_ready = en;
   assign accept    = req_valid && req_ready;

   assign f_cur = at_start_ff ? {1'b0, start_freq} : freq_ff;
   assign freq_in = f_cur + {freq_step[CFG_W-1], freq_step};

   always_comb begin
      hit = 1'b0;
      if (!f_cur[FREQ_W-1]) begin
         hit = (f_cur[CFG_W-1:0] >= win_a_low && f_cur[CFG_W-1:0] <= win_a_high)
            || (f_cur[CFG_W-1:0] >= win_b_low && f_cur[CFG_W-1:0] <= win_b_high);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         freq_ff     <= '0;
         s_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            freq_ff     <= freq_in;
            at_start_ff <= last;
         end
         if (en) begin
            s_valid_ff <= accept;
         end
      end
   end

   function automatic logic [SAMPLE_BITS-1:0] mag_abs(input logic [SAMPLE_BITS-1:0] v);
      mag_abs = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   assign avr = mag_abs(vis_re);
   assign avi = mag_abs(vis_im);
   assign abr = mag_abs(bp_re);
   assign abi = mag_abs(bp_im);

   always_ff @(posedge clock) begin
      if (en) begin
         vsq_ff   <= SQ_W'(avr) * SQ_W'(avr) + SQ_W'(avi) * SQ_W'(avi);
         bsq_ff   <= SQ_W'(abr) * SQ_W'(abr) + SQ_W'(abi) * SQ_W'(abi);
         s_tag_ff <= {hit, last};
      end
   end

   oblr_isqrt #(.IN_W(SQ_W), .OUT_W(RT_W), .TAG_W(2)) u_vis_root (
      .clock, .reset, .en,
      .in_valid (s_valid_ff), .in_x (vsq_ff), .in_tag (s_tag_ff),
      .out_valid (v_out), .out_root (v_root), .out_tag (v_tag)
   );

   oblr_isqrt #(.IN_W(SQ_W), .OUT_W(RT_W), .TAG_W(1)) u_bp_root (
      .clock, .reset, .en,
      .in_valid (s_valid_ff), .in_x (bsq_ff), .in_tag (s_tag_ff[0]),
      .out_valid (b_out), .out_root (b_root), .out_tag (b_tag)
   );

   assign q_valid = v_out && b_out && (b_tag == v_tag[0]);
   assign q_data.vis_mag = MAG_W'(v_root);
   assign q_data.bp_mag  = MAG_W'(b_root);
   assign q_data.hit     = v_tag[1];
   assign q_data.last    = v_tag[0];
endmodule

### sv/oblr_queue.sv
// small fifo between front and back
module oblr_queue
   import oblr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  chan_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output chan_type out_data
);
   localparam int AW = $clog2(QW);

   chan_type        mem_ff [QW];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;
   logic            push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(QW);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

### sv/oblr_back.sv
// accumulation and restoring division of the sums
module oblr_back
   import oblr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  chan_type           q_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [RATIO_W-1:0] level_ratio,
   output logic               zero_level
);
   localparam int NUM_W = SUM_W + 16;
   localparam int CW    = $clog2(NUM_W + 1);

   back_state_type state_ff, state_in;
   logic [SUM_W-1:0]   vis_ff, bp_ff, vis_add, bp_add;
   logic [SUM_W:0]     vsum, bsum;
   logic [NUM_W-1:0]   num_ff;
   logic [SUM_W:0]     rem_ff, rem_sh;
   logic [CW-1:0]      cnt_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic               zero_ff, sat_ff;
   logic               pop;

   assign vsum = {1'b0, vis_ff} + (SUM_W+1)'(q_data.vis_mag);
   assign bsum = {1'b0, bp_ff} + (SUM_W+1)'(q_data.bp_mag);
   assign vis_add = vsum[SUM_W] ? '1 : vsum[SUM_W-1:0];
   assign bp_add  = bsum[SUM_W] ? '1 : bsum[SUM_W-1:0];
   assign rem_sh  = {rem_ff[SUM_W-1:0], num_ff[NUM_W-1]};

   always_comb begin
      state_in = state_ff;
      q_ready  = 1'b0;
      pop      = 1'b0;
      case (state_ff)
         ST_ACC: begin
            q_ready = 1'b1;
            pop     = q_valid;
            if (q_valid && q_data.last) state_in = ST_DIV;
         end
         ST_DIV: if (cnt_ff == '0) state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_ACC;
         default: state_in = ST_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         vis_ff   <= '0;
         bp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (pop && q_data.hit) begin
            vis_ff <= vis_add;
            bp_ff  <= bp_add;
         end
         if (state_ff == ST_OUT && rsp_ready) begin
            vis_ff <= '0;
            bp_ff  <= '0;
         end
      end
      if (pop && q_data.last) begin
         // final sums feed the divider; start from the sums just formed
         num_ff <= {(q_data.hit ? bp_add : bp_ff), 16'h0};
         rem_ff <= '0;
         cnt_ff <= CW'(NUM_W);
         sat_ff <= 1'b0;
      end else if (state_ff == ST_DIV && cnt_ff != '0) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
         if (rem_sh >= {1'b0, vis_ff}) begin
            rem_ff <= rem_sh - {1'b0, vis_ff};
            if (ratio_ff[RATIO_W-1]) sat_ff <= 1'b1;
            ratio_ff <= {ratio_ff[RATIO_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            if (ratio_ff[RATIO_W-1]) sat_ff <= 1'b1;
            ratio_ff <= {ratio_ff[RATIO_W-2:0], 1'b0};
         end
      end
      if (pop && q_data.last) begin
         ratio_ff <= '0;
         zero_ff  <= (q_data.hit ? vis_add : vis_ff) == '0;
      end
   end

   assign rsp_valid   = state_ff == ST_OUT;
   assign level_ratio = (zero_ff || sat_ff) ? '1 : ratio_ff;
   assign zero_level  = zero_ff;
endmodule

### sv/offline_band_level_ratio_top.sv
// offline band level ratio: one spectral channel per beat. a front pipeline
// (one square stage plus one stage per root bit) tracks the channel
// frequency, tests both windows and forms the two floor magnitudes at one
// channel per clock while the queue takes them; a four-entry queue feeds the
// back end, which sums one channel per clock while accumulating and, on the
// last channel, runs a restoring divide of one quotient bit per clock before
// presenting the q16.16 ratio. while the divide runs the queue and the front
// fill and then hold off new beats. zero visibility sum gives all ones and
// zero_level.
module offline_band_level_ratio_top
   import oblr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_vis_re,
   input  logic [SAMPLE_BITS-1:0] req_vis_im,
   input  logic [SAMPLE_BITS-1:0] req_bp_re,
   input  logic [SAMPLE_BITS-1:0] req_bp_im,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [RATIO_W-1:0]     rsp_level_ratio,
   output logic                   rsp_zero_level,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);
   // configuration registers
   logic [CFG_W-1:0] start_freq_ff, freq_step_ff;
   logic [CFG_W-1:0] win_a_low_ff, win_a_high_ff, win_b_low_ff, win_b_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_freq_ff <= '0;
         freq_step_ff  <= CFG_W'(1);
         win_a_low_ff  <= '0;
         win_a_high_ff <= '0;
         win_b_low_ff  <= '0;
         win_b_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_START_FREQ: start_freq_ff <= csr_wdata;
            REG_FREQ_STEP:  freq_step_ff  <= csr_wdata;
            REG_WIN_A_LOW:  win_a_low_ff  <= csr_wdata;
            REG_WIN_A_HIGH: win_a_high_ff <= csr_wdata;
            REG_WIN_B_LOW:  win_b_low_ff  <= csr_wdata;
            REG_WIN_B_HIGH: win_b_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front to queue, queue to back
   logic     f_valid, f_ready, b_valid, b_ready;
   chan_type f_data, b_data;

   oblr_front u_front (
      .clock, .reset, .req_valid, .req_ready,
      .vis_re (req_vis_re), .vis_im (req_vis_im),
      .bp_re (req_bp_re), .bp_im (req_bp_im), .last (req_last),
      .start_freq (start_freq_ff), .freq_step (freq_step_ff),
      .win_a_low (win_a_low_ff), .win_a_high (win_a_high_ff),
      .win_b_low (win_b_low_ff), .win_b_high (win_b_high_ff),
      .q_ready (f_ready), .q_valid (f_valid), .q_data (f_data)
   );

   oblr_queue u_queue (
      .clock, .reset,
      .in_valid (f_valid), .in_ready (f_ready), .in_data (f_data),
      .out_valid (b_valid), .out_ready (b_ready), .out_data (b_data)
   );

   oblr_back u_back (
      .clock, .reset,
      .q_valid (b_valid), .q_ready (b_ready), .q_data (b_data),
      .rsp_valid, .rsp_ready,
      .level_ratio (rsp_level_ratio), .zero_level (rsp_zero_level)
   );
endmodule

### sv/oblr_checker.sv
module oblr_checker
   import oblr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [RATIO_W-1:0] rsp_level_ratio,
   input logic               rsp_zero_level
);
   // zero sum always reads as full scale
   a_zero_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_level |-> rsp_level_ratio == '1)
      else $error("zero level without full scale ratio");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level_ratio))
      else $error("result dropped while stalled");

   // the back end returns to accumulation after each result, so results never come back to back
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("results too close");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");
endmodule

bind offline_band_level_ratio_top oblr_checker u_oblr_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_level_ratio, .rsp_zero_level
);
